// ===== hdl/atrq_pkg.sv =====
package atrq_pkg;

    typedef enum logic [2:0] {
        M_INIT  = 3'd0,
        M_START = 3'd1,
        M_READ  = 3'd2,
        M_CHECK = 3'd3,
        M_END   = 3'd4,
        M_WAIT  = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_OK    = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_START = 2'd1,
        ACC_READ  = 2'd2
    } t_access;

    typedef enum logic [2:0] {
        CFG_TOLERANCE       = 3'd0,
        CFG_READ_GAP        = 3'd1,
        CFG_START_RETRY_GAP = 3'd2,
        CFG_READ_RETRY_GAP  = 3'd3,
        CFG_CHECK_RETRY_GAP = 3'd4,
        CFG_START_RETRY_LIM = 3'd5,
        CFG_READ_RETRY_LIM  = 3'd6,
        CFG_CHECK_RETRY_LIM = 3'd7
    } t_cfg_idx;

    localparam int unsigned CH_MAX = 3;
    localparam logic [8:0] RETRY_MAX = 9'h1FF;
    // ceil(2^17 / 3), exact floor(x / 3) for x below 2^17
    localparam logic [15:0] DIV3_RECIP = 16'd43691;

    typedef struct packed {
        logic [15:0] tolerance;
        logic [15:0] read_gap_ms;
        logic [15:0] start_retry_gap_ms;
        logic [15:0] read_retry_gap_ms;
        logic [15:0] check_retry_gap_ms;
        logic [7:0]  start_retry_limit;
        logic [7:0]  read_retry_limit;
        logic [7:0]  check_retry_limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         channel;
        logic [31:0]        now_ms;
        logic               bus_ok;
        logic signed [15:0] sample;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic signed [15:0] average_value;
        t_access            access;
        logic [1:0]         access_channel;
    } t_result;

    function automatic logic signed [15:0] div3(input logic signed [15:0] x);
        logic [16:0] mag;
        logic [32:0] prod;
        logic [15:0] q;
        mag  = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
        prod = mag * DIV3_RECIP;
        q    = prod[32:17];
        return x[15] ? $signed(16'd0 - q) : $signed(q);
    endfunction

    function automatic logic [16:0] absdiff(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
        logic [17:0] d;
        d = {{2{a[15]}}, a} - {{2{b[15]}}, b};
        return d[17] ? 17'(18'd0 - d) : d[16:0];
    endfunction

endpackage

// ===== hdl/atrq_if.sv =====
interface atrq_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         channel;
    logic [31:0]        now_ms;
    logic               bus_ok;
    logic signed [15:0] sample;

    modport source (output valid, channel, now_ms, bus_ok, sample, input ready);
    modport sink   (input valid, channel, now_ms, bus_ok, sample, output ready);
endinterface

interface atrq_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [15:0] average_value;
    logic [1:0]         access;
    logic [1:0]         access_channel;

    modport source (output valid, status, average_value, access, access_channel,
                    input ready);
    modport sink   (input valid, status, average_value, access, access_channel,
                    output ready);
endinterface

interface atrq_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/atrq_seq.sv =====
module atrq_seq #(
    parameter int unsigned CONVERSION_WAIT_MS = 130
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  atrq_pkg::t_item i_item,
    input  atrq_pkg::t_cfg  i_cfg,
    output atrq_pkg::t_result o_res
);

    localparam logic [15:0] CONV_WAIT = 16'(CONVERSION_WAIT_MS);

    atrq_pkg::t_mode    r_mode, n_mode;
    atrq_pkg::t_mode    r_resume, n_resume;
    logic [8:0]         r_retry, n_retry;
    logic signed [15:0] r_read [3];
    logic signed [15:0] n_read [3];
    logic signed [15:0] r_third [3];
    logic signed [15:0] n_third [3];
    logic [1:0]         r_idx, n_idx;
    logic [31:0]        r_wait_start, n_wait_start;
    logic [15:0]        r_wait_len, n_wait_len;
    logic               r_failed, n_failed;
    atrq_pkg::t_status  r_held_status, n_held_status;
    logic signed [15:0] r_held_value, n_held_value;

    atrq_pkg::t_access  w_access;
    logic [1:0]         w_access_ch;
    logic               w_ch_ok;
    logic [8:0]         w_retry_inc;
    logic [1:0]         w_widx;
    logic [31:0]        w_elapsed;
    logic               w_agree;
    logic signed [15:0] w_sample_third;

    assign w_ch_ok        = i_item.channel <= 3'(atrq_pkg::CH_MAX);
    assign w_retry_inc    = (r_retry == atrq_pkg::RETRY_MAX) ? r_retry : r_retry + 9'd1;
    assign w_widx         = (r_idx > 2'd2) ? 2'd2 : r_idx;
    assign w_elapsed      = i_item.now_ms - r_wait_start;
    assign w_sample_third = atrq_pkg::div3(i_item.sample);
    assign w_agree = (atrq_pkg::absdiff(r_read[0], r_read[1]) < {1'b0, i_cfg.tolerance})
                  && (atrq_pkg::absdiff(r_read[1], r_read[2]) < {1'b0, i_cfg.tolerance})
                  && (atrq_pkg::absdiff(r_read[0], r_read[2]) < {1'b0, i_cfg.tolerance});

    always_comb begin
        n_mode        = r_mode;
        n_resume      = r_resume;
        n_retry       = r_retry;
        n_read        = r_read;
        n_third       = r_third;
        n_idx         = r_idx;
        n_wait_start  = r_wait_start;
        n_wait_len    = r_wait_len;
        n_failed      = r_failed;
        n_held_status = r_held_status;
        n_held_value  = r_held_value;
        w_access      = atrq_pkg::ACC_NONE;
        w_access_ch   = 2'd0;
        unique case (r_mode)
            atrq_pkg::M_START: begin
                if (w_ch_ok) begin
                    w_access    = atrq_pkg::ACC_START;
                    w_access_ch = i_item.channel[1:0];
                end
                n_wait_start = i_item.now_ms;
                n_mode       = atrq_pkg::M_WAIT;
                if (w_ch_ok && i_item.bus_ok) begin
                    n_retry    = 9'd0;
                    n_wait_len = CONV_WAIT;
                    n_resume   = atrq_pkg::M_READ;
                end else if (r_retry < {1'b0, i_cfg.start_retry_limit}) begin
                    n_retry    = w_retry_inc;
                    n_wait_len = i_cfg.start_retry_gap_ms;
                    n_resume   = atrq_pkg::M_START;
                end else begin
                    n_wait_start = r_wait_start;
                    n_retry      = 9'd0;
                    n_failed     = 1'b1;
                    n_mode       = atrq_pkg::M_END;
                end
            end
            atrq_pkg::M_READ: begin
                w_access = atrq_pkg::ACC_READ;
                n_read[w_widx]  = i_item.bus_ok ? i_item.sample : -16'sd1;
                n_third[w_widx] = i_item.bus_ok ? w_sample_third : 16'sd0;
                if (i_item.bus_ok) begin
                    n_mode = atrq_pkg::M_CHECK;
                end else if (r_retry < {1'b0, i_cfg.read_retry_limit}) begin
                    n_retry      = w_retry_inc;
                    n_wait_start = i_item.now_ms;
                    n_wait_len   = i_cfg.read_retry_gap_ms;
                    n_resume     = atrq_pkg::M_READ;
                    n_mode       = atrq_pkg::M_WAIT;
                end else begin
                    n_retry  = 9'd0;
                    n_failed = 1'b1;
                    n_mode   = atrq_pkg::M_END;
                end
            end
            atrq_pkg::M_CHECK: begin
                if (r_idx >= 2'd2) begin
                    n_idx = 2'd0;
                    if (w_agree) begin
                        n_retry      = 9'd0;
                        n_held_value = r_third[0] + r_third[1] + r_third[2];
                        n_mode       = atrq_pkg::M_END;
                    end else if (r_retry < {1'b0, i_cfg.check_retry_limit}) begin
                        n_retry      = w_retry_inc;
                        n_wait_start = i_item.now_ms;
                        n_wait_len   = i_cfg.check_retry_gap_ms;
                        n_resume     = atrq_pkg::M_READ;
                        n_mode       = atrq_pkg::M_WAIT;
                    end else begin
                        n_retry  = 9'd0;
                        n_failed = 1'b1;
                        n_mode   = atrq_pkg::M_END;
                    end
                end else begin
                    n_idx        = r_idx + 2'd1;
                    n_wait_start = i_item.now_ms;
                    n_wait_len   = i_cfg.read_gap_ms;
                    n_resume     = atrq_pkg::M_READ;
                    n_mode       = atrq_pkg::M_WAIT;
                end
            end
            atrq_pkg::M_END: begin
                n_held_status = r_failed ? atrq_pkg::ST_ERROR : atrq_pkg::ST_OK;
                n_mode        = atrq_pkg::M_INIT;
            end
            atrq_pkg::M_WAIT: begin
                if (w_elapsed > {16'd0, r_wait_len}) begin
                    n_mode = r_resume;
                end
            end
            default: begin
                n_read        = '{-16'sd1, -16'sd1, -16'sd1};
                n_third       = '{16'sd0, 16'sd0, 16'sd0};
                n_retry       = 9'd0;
                n_failed      = 1'b0;
                n_resume      = atrq_pkg::M_INIT;
                n_mode        = atrq_pkg::M_START;
                n_held_status = atrq_pkg::ST_BUSY;
                n_idx         = 2'd0;
            end
        endcase
    end

    always_comb begin
        o_res.status         = n_held_status;
        o_res.average_value  = n_held_value;
        o_res.access         = w_access;
        o_res.access_channel = w_access_ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= atrq_pkg::M_INIT;
            r_resume      <= atrq_pkg::M_INIT;
            r_retry       <= 9'd0;
            r_read        <= '{-16'sd1, -16'sd1, -16'sd1};
            r_third       <= '{16'sd0, 16'sd0, 16'sd0};
            r_idx         <= 2'd0;
            r_wait_start  <= 32'd0;
            r_wait_len    <= 16'd0;
            r_failed      <= 1'b0;
            r_held_status <= atrq_pkg::ST_BUSY;
            r_held_value  <= 16'sd0;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_resume      <= n_resume;
            r_retry       <= n_retry;
            r_read        <= n_read;
            r_third       <= n_third;
            r_idx         <= n_idx;
            r_wait_start  <= n_wait_start;
            r_wait_len    <= n_wait_len;
            r_failed      <= n_failed;
            r_held_status <= n_held_status;
            r_held_value  <= n_held_value;
        end
    end

    a_end_to_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_mode == atrq_pkg::M_END |=> r_mode == atrq_pkg::M_INIT
            && (r_held_status == atrq_pkg::ST_OK || r_held_status == atrq_pkg::ST_ERROR))
        else $error("end poll did not settle status");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("reading index out of range");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_mode) && $stable(r_retry) && $stable(r_held_value))
        else $error("state changed without a poll");

endmodule

// ===== hdl/adc_triple_read_qualifier.sv =====
// Triple-read ADC acquisition qualifier.
//
// i_in carries one poll of the acquisition sequencer per item: channel, the
// millisecond time stamp, the outcome of the poll's bus access and the read
// data. o_out returns exactly one item per poll: held status, last qualified
// average, the bus access the poll stood for and its channel. i_cfg writes
// the eight tuning registers (tolerance, gaps, retry limits) by index; it is
// always ready; the user writes it only while no poll is in flight, unchecked.
//
// A poll passes the input register, then the sequencer step into the result
// register, which raises o_out.valid. Throughput is one poll per cycle while
// the receiver does not stall; the divide by three of each reading is done
// as it is stored, so the check poll only adds.
//
// Reset returns the registers to their defaults and the sequencer to init,
// status busy, average zero. When the receiver stalls, the result register
// holds, the input register still takes one more poll, then i_in.ready drops.
module adc_triple_read_qualifier #(
    parameter int unsigned CONVERSION_WAIT_MS = 130
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    atrq_in_if.sink    i_in,
    atrq_out_if.source o_out,
    atrq_cfg_if.sink   i_cfg
);

    atrq_pkg::t_cfg    r_cfg;
    atrq_pkg::t_item   r_item;
    logic              r_in_valid;
    atrq_pkg::t_result r_res;
    logic              r_out_valid;
    atrq_pkg::t_result w_res;
    logic              w_step;

    assign w_step      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_step;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tolerance          <= 16'd16;
            r_cfg.read_gap_ms        <= 16'd10;
            r_cfg.start_retry_gap_ms <= 16'd10;
            r_cfg.read_retry_gap_ms  <= 16'd10;
            r_cfg.check_retry_gap_ms <= 16'd10;
            r_cfg.start_retry_limit  <= 8'd3;
            r_cfg.read_retry_limit   <= 8'd3;
            r_cfg.check_retry_limit  <= 8'd3;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                atrq_pkg::CFG_TOLERANCE:       r_cfg.tolerance          <= i_cfg.data;
                atrq_pkg::CFG_READ_GAP:        r_cfg.read_gap_ms        <= i_cfg.data;
                atrq_pkg::CFG_START_RETRY_GAP: r_cfg.start_retry_gap_ms <= i_cfg.data;
                atrq_pkg::CFG_READ_RETRY_GAP:  r_cfg.read_retry_gap_ms  <= i_cfg.data;
                atrq_pkg::CFG_CHECK_RETRY_GAP: r_cfg.check_retry_gap_ms <= i_cfg.data;
                atrq_pkg::CFG_START_RETRY_LIM: r_cfg.start_retry_limit  <= i_cfg.data[7:0];
                atrq_pkg::CFG_READ_RETRY_LIM:  r_cfg.read_retry_limit   <= i_cfg.data[7:0];
                atrq_pkg::CFG_CHECK_RETRY_LIM: r_cfg.check_retry_limit  <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.channel <= i_in.channel;
            r_item.now_ms  <= i_in.now_ms;
            r_item.bus_ok  <= i_in.bus_ok;
            r_item.sample  <= i_in.sample;
        end
    end

    atrq_seq #(
        .CONVERSION_WAIT_MS(CONVERSION_WAIT_MS)
    ) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (w_step),
        .i_item (r_item),
        .i_cfg  (r_cfg),
        .o_res  (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_res.status;
    assign o_out.average_value  = r_res.average_value;
    assign o_out.access         = r_res.access;
    assign o_out.access_channel = r_res.access_channel;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_step |=> r_in_valid && $stable(r_item))
        else $error("pending item lost");

    a_step_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("poll result not presented");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !w_step)
        else $error("result overwritten while stalled");

endmodule
